>>> sv/rsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// rsi_pkg: widths, constants and shared types of the ray-sphere intersect block
// no dependencies; used by rsi_sqrt, rsi_div and ray_sphere_intersect
package rsi_pkg;

  localparam int COORD_W       = 32;
  localparam int RADIUS_W      = 31;
  localparam int DIST_W        = 31;
  localparam int FRAC_BITS_DEF = 16;

  // exact integer widths of the intermediates
  localparam int OC_W   = 33;   // origin minus centre
  localparam int A_W    = 64;   // d.d
  localparam int H_W    = 67;   // oc.d, signed
  localparam int C_W    = 67;   // oc.oc - r*r, signed
  localparam int MAG_W  = 66;   // magnitudes of h and c
  localparam int LIMB_W = 33;   // limb of the split multipliers
  localparam int PROD_W = 132;  // h*h and a*|c|
  localparam int DISC_W = 133;  // signed discriminant
  localparam int RAD_W  = 132;  // sqrt operand
  localparam int ROOT_W = 66;   // sqrt result
  localparam int PICK_W = 68;   // chosen root numerator

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // data that rides along the square root pipeline
  typedef struct packed {
    logic [H_W-1:0] h;
    logic [A_W-1:0] a;
    logic           nohit;
  } sqrt_side_t;

endpackage
`default_nettype wire

>>> sv/ray_sphere_intersect.sv
`timescale 1ns / 1ps
`default_nettype none
// ray_sphere_intersect: fixed-point ray against sphere, nearer positive root
// throughput: one transaction per cycle while the output is not stalled; a full 108-stage pipeline sets the latency
// a stalled output freezes every stage, so in_ready follows the output register
// reset (synchronous, rst_n low): all valid bits clear, radius returns to 0.15
// depends on rsi_pkg, rsi_sqrt and rsi_div
module ray_sphere_intersect #(
  parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [rsi_pkg::RADIUS_W-1:0]  cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rsi_pkg::COORD_W-1:0]   in_origin_x,
  input  wire logic [rsi_pkg::COORD_W-1:0]   in_origin_y,
  input  wire logic [rsi_pkg::COORD_W-1:0]   in_origin_z,
  input  wire logic [rsi_pkg::COORD_W-1:0]   in_dir_x,
  input  wire logic [rsi_pkg::COORD_W-1:0]   in_dir_y,
  input  wire logic [rsi_pkg::COORD_W-1:0]   in_dir_z,
  input  wire logic [rsi_pkg::COORD_W-1:0]   in_center_x,
  input  wire logic [rsi_pkg::COORD_W-1:0]   in_center_y,
  input  wire logic [rsi_pkg::COORD_W-1:0]   in_center_z,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_hit,
  output logic [rsi_pkg::DIST_W-1:0]         out_distance
);

  localparam int CW  = rsi_pkg::COORD_W;
  localparam int OW  = rsi_pkg::OC_W;
  localparam int AW  = rsi_pkg::A_W;
  localparam int HW  = rsi_pkg::H_W;
  localparam int KW  = rsi_pkg::C_W;
  localparam int MW  = rsi_pkg::MAG_W;
  localparam int LW  = rsi_pkg::LIMB_W;
  localparam int PW  = rsi_pkg::PROD_W;
  localparam int DSW = rsi_pkg::DISC_W;
  localparam int RDW = rsi_pkg::RAD_W;
  localparam int RTW = rsi_pkg::ROOT_W;
  localparam int PKW = rsi_pkg::PICK_W;
  localparam int RW  = rsi_pkg::RADIUS_W;
  localparam int NXW = PKW + 1;  // signed root numerators

  // radius reset: floor(0.15 * 2^FRAC_BITS)
  localparam logic [RW-1:0] RADIUS_RST = RW'((64'd15 << FRAC_BITS) / 64'd100);

  // -------------------------------------------------------------------------
  // global advance: every stage moves when the output register can take data
  // -------------------------------------------------------------------------
  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // configuration register, to be written only while the pipeline is empty; the block itself does not enforce this
  logic [RW-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  // -------------------------------------------------------------------------
  // stage 1: oc = origin - centre, register the direction
  // -------------------------------------------------------------------------
  logic [CW-1:0] org [3];
  logic [CW-1:0] dir [3];
  logic [CW-1:0] cen [3];

  assign org[0] = in_origin_x;
  assign org[1] = in_origin_y;
  assign org[2] = in_origin_z;
  assign dir[0] = in_dir_x;
  assign dir[1] = in_dir_y;
  assign dir[2] = in_dir_z;
  assign cen[0] = in_center_x;
  assign cen[1] = in_center_y;
  assign cen[2] = in_center_z;

  logic          s1_v_r;
  logic [OW-1:0] oc_r [3];
  logic [CW-1:0] d_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        oc_r[i] <= {org[i][CW-1], org[i]} - {cen[i][CW-1], cen[i]};
        d_r[i]  <= dir[i];
      end
    end
  end

  // -------------------------------------------------------------------------
  // stage 2: the per-axis products and r*r, one multiplier each
  // -------------------------------------------------------------------------
  logic signed [2*CW-1:0]   dd_w [3];
  logic signed [OW+CW-1:0]  od_w [3];
  logic signed [2*OW-1:0]   oo_w [3];

  for (genvar i = 0; i < 3; i++) begin : g_prod
    assign dd_w[i] = $signed(d_r[i]) * $signed(d_r[i]);
    assign od_w[i] = $signed(oc_r[i]) * $signed(d_r[i]);
    assign oo_w[i] = $signed(oc_r[i]) * $signed(oc_r[i]);
  end

  logic               s2_v_r;
  logic [2*CW-1:0]    dd_r [3];
  logic [OW+CW-1:0]   od_r [3];
  logic [2*CW-1:0]    oo_r [3];  // |oc| < 2^32, so the square fits 64 bits
  logic [2*RW-1:0]    rr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dd_r[i] <= dd_w[i];
        od_r[i] <= od_w[i];
        oo_r[i] <= oo_w[i][2*CW-1:0];
      end
      rr_r <= radius_r * radius_r;
    end
  end

  // -------------------------------------------------------------------------
  // stage 3: a = d.d, h = oc.d, c = oc.oc - r*r
  // -------------------------------------------------------------------------
  logic          s3_v_r;
  logic [AW-1:0] a3_r;
  logic [HW-1:0] h3_r;
  logic [KW-1:0] c3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3_r <= dd_r[0] + dd_r[1] + dd_r[2];
      h3_r <= {{2{od_r[0][OW+CW-1]}}, od_r[0]} + {{2{od_r[1][OW+CW-1]}}, od_r[1]}
            + {{2{od_r[2][OW+CW-1]}}, od_r[2]};
      c3_r <= KW'(oo_r[0]) + KW'(oo_r[1]) + KW'(oo_r[2]) - KW'(rr_r);
    end
  end

  // -------------------------------------------------------------------------
  // stage 4: magnitudes of h and c for the unsigned limb multipliers
  // -------------------------------------------------------------------------
  logic [HW-1:0] hneg_w;
  logic [KW-1:0] cneg_w;

  assign hneg_w = -h3_r;
  assign cneg_w = -c3_r;

  logic          s4_v_r;
  logic [MW-1:0] hm4_r;
  logic [MW-1:0] cm4_r;
  logic          cs4_r;
  logic          az4_r;
  logic [AW-1:0] a4_r;
  logic [HW-1:0] h4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hm4_r <= h3_r[HW-1] ? hneg_w[MW-1:0] : h3_r[MW-1:0];
      cm4_r <= c3_r[KW-1] ? cneg_w[MW-1:0] : c3_r[MW-1:0];
      cs4_r <= c3_r[KW-1];
      az4_r <= (a3_r == '0);
      a4_r  <= a3_r;
      h4_r  <= h3_r;
    end
  end

  // -------------------------------------------------------------------------
  // stage 5: 33-bit limb partial products of h*h and a*|c|
  // -------------------------------------------------------------------------
  logic [LW-1:0] a_lo_w;
  logic [LW-1:0] a_hi_w;

  assign a_lo_w = a4_r[LW-1:0];
  assign a_hi_w = LW'(a4_r[AW-1:LW]);

  logic            s5_v_r;
  logic [2*LW-1:0] hp00_r;
  logic [2*LW-1:0] hp01_r;
  logic [2*LW-1:0] hp11_r;
  logic [2*LW-1:0] ap00_r;
  logic [2*LW-1:0] ap01_r;
  logic [2*LW-1:0] ap10_r;
  logic [2*LW-1:0] ap11_r;
  logic            cs5_r;
  logic            az5_r;
  logic [AW-1:0]   a5_r;
  logic [HW-1:0]   h5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hp00_r <= hm4_r[LW-1:0] * hm4_r[LW-1:0];
      hp01_r <= hm4_r[LW-1:0] * hm4_r[MW-1:LW];
      hp11_r <= hm4_r[MW-1:LW] * hm4_r[MW-1:LW];
      ap00_r <= a_lo_w * cm4_r[LW-1:0];
      ap01_r <= a_lo_w * cm4_r[MW-1:LW];
      ap10_r <= a_hi_w * cm4_r[LW-1:0];
      ap11_r <= a_hi_w * cm4_r[MW-1:LW];
      cs5_r  <= cs4_r;
      az5_r  <= az4_r;
      a5_r   <= a4_r;
      h5_r   <= h4_r;
    end
  end

  // -------------------------------------------------------------------------
  // stage 6: cross terms summed, outer terms placed side by side
  // -------------------------------------------------------------------------
  logic              s6_v_r;
  logic [2*LW:0]     hmid6_r;
  logic [PW-1:0]     hcat6_r;
  logic [2*LW:0]     amid6_r;
  logic [PW-1:0]     acat6_r;
  logic              cs6_r;
  logic              az6_r;
  logic [AW-1:0]     a6_r;
  logic [HW-1:0]     h6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hmid6_r <= {hp01_r, 1'b0};  // both cross terms of a square are equal
      hcat6_r <= {hp11_r, hp00_r};
      amid6_r <= {1'b0, ap01_r} + {1'b0, ap10_r};
      acat6_r <= {ap11_r, ap00_r};
      cs6_r   <= cs5_r;
      az6_r   <= az5_r;
      a6_r    <= a5_r;
      h6_r    <= h5_r;
    end
  end

  // -------------------------------------------------------------------------
  // stage 7: full products
  // -------------------------------------------------------------------------
  logic          s7_v_r;
  logic [PW-1:0] hsq7_r;
  logic [PW-1:0] acp7_r;
  logic          cs7_r;
  logic          az7_r;
  logic [AW-1:0] a7_r;
  logic [HW-1:0] h7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (en) begin
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hsq7_r <= hcat6_r + (PW'(hmid6_r) << LW);
      acp7_r <= acat6_r + (PW'(amid6_r) << LW);
      cs7_r  <= cs6_r;
      az7_r  <= az6_r;
      a7_r   <= a6_r;
      h7_r   <= h6_r;
    end
  end

  // -------------------------------------------------------------------------
  // stage 8: discriminant h*h - a*c, sign of c folded into add or subtract
  // -------------------------------------------------------------------------
  logic           s8_v_r;
  logic [DSW-1:0] disc8_r;
  logic           az8_r;
  logic [AW-1:0]  a8_r;
  logic [HW-1:0]  h8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else if (en) begin
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disc8_r <= cs7_r ? ({1'b0, hsq7_r} + {1'b0, acp7_r})
                       : ({1'b0, hsq7_r} - {1'b0, acp7_r});
      az8_r   <= az7_r;
      a8_r    <= a7_r;
      h8_r    <= h7_r;
    end
  end

  // -------------------------------------------------------------------------
  // square root of the discriminant, 66 stages
  // a negative discriminant or a zero direction is flagged as a miss; a negative one feeds zero to the root
  // -------------------------------------------------------------------------
  logic [RDW-1:0]      sq_rad;
  rsi_pkg::sqrt_side_t sq_side_in;
  logic                sq_v;
  logic [RTW-1:0]      sq_root;
  rsi_pkg::sqrt_side_t sq_side;

  assign sq_rad           = disc8_r[DSW-1] ? '0 : disc8_r[RDW-1:0];
  assign sq_side_in.h     = h8_r;
  assign sq_side_in.a     = a8_r;
  assign sq_side_in.nohit = az8_r || disc8_r[DSW-1];

  rsi_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s8_v_r),
    .in_rad    (sq_rad),
    .in_side   (sq_side_in),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // -------------------------------------------------------------------------
  // root selection: n1 = -h - sqrt, n2 = -h + sqrt; first positive one wins
  // -------------------------------------------------------------------------
  logic [NXW-1:0] hx_w;
  logic [NXW-1:0] rx_w;
  logic [NXW-1:0] n1_w;
  logic [NXW-1:0] n2_w;
  logic           n1_pos;
  logic           n2_pos;

  assign hx_w   = {{(NXW-HW){sq_side.h[HW-1]}}, sq_side.h};
  assign rx_w   = NXW'(sq_root);
  assign n1_w   = -hx_w - rx_w;
  assign n2_w   = rx_w - hx_w;
  assign n1_pos = !n1_w[NXW-1] && (n1_w != '0);
  assign n2_pos = !n2_w[NXW-1] && (n2_w != '0);

  logic           pk_v_r;
  logic [PKW-1:0] pk_num_r;
  logic [AW-1:0]  pk_a_r;
  logic           pk_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pk_v_r <= 1'b0;
    end else if (en) begin
      pk_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pk_num_r <= n1_pos ? n1_w[PKW-1:0] : n2_w[PKW-1:0];
      pk_a_r   <= sq_side.a;
      pk_hit_r <= !sq_side.nohit && (n1_pos || n2_pos);
    end
  end

  // -------------------------------------------------------------------------
  // distance = floor(num * 2^FRAC_BITS / a), saturated, 32 stages
  // -------------------------------------------------------------------------
  logic                          dv_v;
  logic                          dv_hit;
  logic                          dv_sat;
  logic [rsi_pkg::DIST_W-1:0]    dv_quo;

  rsi_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pk_v_r),
    .in_num    (pk_num_r),
    .in_den    (pk_a_r),
    .in_hit    (pk_hit_r),
    .out_valid (dv_v),
    .out_hit   (dv_hit),
    .out_sat   (dv_sat),
    .out_quo   (dv_quo)
  );

  // -------------------------------------------------------------------------
  // output register: holds a finished transaction until out_ready
  // -------------------------------------------------------------------------
  logic                       out_hit_r;
  logic [rsi_pkg::DIST_W-1:0] out_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r  <= dv_hit;
      out_dist_r <= !dv_hit ? '0 : (dv_sat ? rsi_pkg::DIST_MAX : dv_quo);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_distance = out_dist_r;

`ifndef SYNTHESIS
  // a miss always reports zero distance
  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_hit_r || (out_dist_r == '0)))
    else $error("miss with nonzero distance");

  // a flagged miss from the discriminant stage never turns into a hit
  a_nohit_kept : assert property (@(posedge clk) disable iff (!rst_n)
    (en && sq_v && sq_side.nohit) |=> !pk_hit_r)
    else $error("flagged miss became a hit");

  // reset empties the output register
  a_rst_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

>>> sv/rsi_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// rsi_sqrt: pipelined integer square root (floor), one result bit per stage
// depends on rsi_pkg for widths and the sideband type
module rsi_sqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [rsi_pkg::RAD_W-1:0] in_rad,
  input  wire rsi_pkg::sqrt_side_t       in_side,
  output logic                           out_valid,
  output logic [rsi_pkg::ROOT_W-1:0]     out_root,
  output rsi_pkg::sqrt_side_t            out_side
);

  localparam int RW = rsi_pkg::ROOT_W;
  localparam int XW = rsi_pkg::RAD_W;

  logic                v_r    [RW];
  logic [XW-1:0]       rad_r  [RW];
  logic [RW+1:0]       rem_r  [RW];
  logic [RW-1:0]       root_r [RW];
  rsi_pkg::sqrt_side_t side_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_st
    logic                v_i;
    logic [XW-1:0]       rad_i;
    logic [RW+1:0]       rem_i;
    logic [RW-1:0]       root_i;
    rsi_pkg::sqrt_side_t side_i;
    logic [RW+3:0]       rem_sh;
    logic [RW+3:0]       trial;
    logic [RW+3:0]       diff;
    logic                ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rad_i  = in_rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign side_i = side_r[k-1];
    end

    // bring down the next two operand bits and try root*4+1
    assign rem_sh = {rem_i, rad_i[XW-1 -: 2]};
    assign trial  = {2'b00, root_i, 2'b01};
    assign diff   = rem_sh - trial;
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_i << 2;
        rem_r[k]  <= ge ? diff[RW+1:0] : rem_sh[RW+1:0];
        root_r[k] <= {root_i[RW-2:0], ge};
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule
`default_nettype wire

>>> sv/rsi_div.sv
`timescale 1ns / 1ps
`default_nettype none
// rsi_div: pipelined restoring divider, numerator scaled by FRAC_BITS,
// quotient limited to the distance width with a saturation flag; uses rsi_pkg
module rsi_div #(
  parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [rsi_pkg::PICK_W-1:0] in_num,
  input  wire logic [rsi_pkg::A_W-1:0]    in_den,
  input  wire logic                       in_hit,
  output logic                            out_valid,
  output logic                            out_hit,
  output logic                            out_sat,
  output logic [rsi_pkg::DIST_W-1:0]      out_quo
);

  localparam int QW = rsi_pkg::DIST_W;
  localparam int DW = rsi_pkg::A_W;
  localparam int NW = rsi_pkg::PICK_W + FRAC_BITS;
  localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  // entry stage: scale the numerator, decide saturation up front
  logic          e_v_r;
  logic [CW-1:0] e_rem_r;
  logic [DW-1:0] e_den_r;
  logic          e_hit_r;
  logic          e_sat_r;
  logic [CW-1:0] num_sh;
  logic [CW-1:0] den_top;

  assign num_sh  = CW'(in_num) << FRAC_BITS;
  assign den_top = CW'(in_den) << QW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_rem_r <= num_sh;
      e_den_r <= in_den;
      e_hit_r <= in_hit;
      e_sat_r <= (num_sh >= den_top);
    end
  end

  logic          v_r   [QW];
  logic [CW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic          hit_r [QW];
  logic          sat_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    localparam int B = QW - 1 - k;
    logic          v_i;
    logic [CW-1:0] rem_i;
    logic [DW-1:0] den_i;
    logic [QW-1:0] quo_i;
    logic          hit_i;
    logic          sat_i;
    logic [CW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_i   = e_v_r;
      assign rem_i = e_rem_r;
      assign den_i = e_den_r;
      assign quo_i = '0;
      assign hit_i = e_hit_r;
      assign sat_i = e_sat_r;
    end else begin : g_next
      assign v_i   = v_r[k-1];
      assign rem_i = rem_r[k-1];
      assign den_i = den_r[k-1];
      assign quo_i = quo_r[k-1];
      assign hit_i = hit_r[k-1];
      assign sat_i = sat_r[k-1];
    end

    assign trial = CW'(den_i) << B;
    assign ge    = (rem_i >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? (rem_i - trial) : rem_i;
        den_r[k] <= den_i;
        quo_r[k] <= quo_i | (QW'(ge) << B);
        hit_r[k] <= hit_i;
        sat_r[k] <= sat_i;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_hit   = hit_r[QW-1];
  assign out_sat   = sat_r[QW-1];
  assign out_quo   = quo_r[QW-1];

endmodule
`default_nettype wire
